// File: rtl/fdrle_pkg.sv
// Shared types and constants for the frame delta run-length encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package fdrle_pkg;

    localparam int COLOR_W = 8;
    localparam int PIX_W   = 3 * COLOR_W;
    localparam int LEN_W   = 25;
    localparam int KIND_W  = 2;

    localparam int MAX_RAW_RUN_DEF = 32;

    // Same-run counts saturate at the frame bound
    localparam logic [LEN_W-1:0] MAX_FRAME_PIXELS = 25'd16777216;

    // Result item kinds
    localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAME  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic update;
        logic load_hdr;
        logic load_pix;
        logic clear_run;
        logic flush_post;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pre_flush;
        logic last;
        logic run_same;
        logic out_free;
        logic pix_final;
    } ctrl_status_t;

endpackage

`default_nettype wire

// File: rtl/frame_delta_run_length_encoder_top.sv
// Frame delta run-length encoder, top level: controller plus datapath.
// The first result of an item passes capture, evaluation and the header load before it is valid.
// A new item is taken only once the last is done: each flushed header and raw pixel adds a load,
// and a flush that ends a run mid-frame returns to evaluation to resume the update.
// Reset: rst_n asynchronous active low; no run open, result register empty.
// Depends on fdrle_pkg, fdrle_ctrl, fdrle_datapath and fdrle_ram.
`default_nettype none

module frame_delta_run_length_encoder_top
    import fdrle_pkg::*;
#(
    parameter int MAX_RAW_RUN = MAX_RAW_RUN_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [COLOR_W-1:0]  cur_red,
    input  wire logic [COLOR_W-1:0]  cur_green,
    input  wire logic [COLOR_W-1:0]  cur_blue,
    input  wire logic [COLOR_W-1:0]  ref_red,
    input  wire logic [COLOR_W-1:0]  ref_green,
    input  wire logic [COLOR_W-1:0]  ref_blue,
    input  wire logic                frame_end,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [KIND_W-1:0]   item_kind,
    output logic      [LEN_W-1:0]    run_length,
    output logic      [COLOR_W-1:0]  out_red,
    output logic      [COLOR_W-1:0]  out_green,
    output logic      [COLOR_W-1:0]  out_blue,
    output logic                     burst_last
);

    // The controller captures one item at a time, then walks it through:
    // optional flush of the run it ends, the run update, and at frame end
    // a flush of the run it leaves open. Raw pixels stream out of the buffer.
    ctrl_cmd_t    cmd;
    ctrl_status_t st;

    fdrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    fdrle_datapath #(
        .MAX_RAW_RUN (MAX_RAW_RUN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .cur_red    (cur_red),
        .cur_green  (cur_green),
        .cur_blue   (cur_blue),
        .ref_red    (ref_red),
        .ref_green  (ref_green),
        .ref_blue   (ref_blue),
        .frame_end  (frame_end),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .item_kind  (item_kind),
        .run_length (run_length),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .burst_last (burst_last)
    );

endmodule

`default_nettype wire

// File: rtl/fdrle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on fdrle_pkg for default widths.
`default_nettype none

module fdrle_ram
    import fdrle_pkg::*;
#(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = MAX_RAW_RUN_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/fdrle_datapath.sv
// Datapath: captured pixel, run state, raw pixel buffer and result register.
// Depends on fdrle_pkg and fdrle_ram.
`default_nettype none

module fdrle_datapath
    import fdrle_pkg::*;
#(
    parameter int MAX_RAW_RUN = MAX_RAW_RUN_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctrl_cmd_t           cmd,
    output ctrl_status_t             st,
    input  wire logic [COLOR_W-1:0]  cur_red,
    input  wire logic [COLOR_W-1:0]  cur_green,
    input  wire logic [COLOR_W-1:0]  cur_blue,
    input  wire logic [COLOR_W-1:0]  ref_red,
    input  wire logic [COLOR_W-1:0]  ref_green,
    input  wire logic [COLOR_W-1:0]  ref_blue,
    input  wire logic                frame_end,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic      [KIND_W-1:0]   item_kind,
    output logic      [LEN_W-1:0]    run_length,
    output logic      [COLOR_W-1:0]  out_red,
    output logic      [COLOR_W-1:0]  out_green,
    output logic      [COLOR_W-1:0]  out_blue,
    output logic                     burst_last
);

    localparam int AW = (MAX_RAW_RUN > 1) ? $clog2(MAX_RAW_RUN) : 1;
    localparam logic [LEN_W-1:0] RAW_LIMIT = LEN_W'(MAX_RAW_RUN);

    logic [PIX_W-1:0]   pix_reg;
    logic               same_reg;
    logic               last_reg;
    logic [LEN_W-1:0]   count_reg,   count_next;
    logic               is_same_reg, is_same_next;
    logic [AW-1:0]      pix_idx_reg, pix_idx_next;

    logic               out_valid_reg,  out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg,   out_kind_next;
    logic [LEN_W-1:0]   out_len_reg,    out_len_next;
    logic [PIX_W-1:0]   out_pix_reg,    out_pix_next;
    logic               out_last_reg,   out_last_next;

    logic               run_open;
    logic               pre_flush;
    logic               open_new;
    logic               burst_end;
    logic               pix_final;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [PIX_W-1:0]   ram_rdata;

    assign run_open  = (count_reg != '0);
    assign pre_flush = run_open &&
                       ((same_reg != is_same_reg) || (!same_reg && (count_reg >= RAW_LIMIT)));
    assign open_new  = !run_open || pre_flush;
    assign burst_end = cmd.flush_post || !last_reg;
    assign pix_final = ((LEN_W'(pix_idx_reg) + LEN_W'(1)) == count_reg);

    assign st.pre_flush = pre_flush;
    assign st.last      = last_reg;
    assign st.run_same  = is_same_reg;
    assign st.out_free  = !out_valid_reg || !out_stall;
    assign st.pix_final = pix_final;

    // Buffer raw pixels: a new raw run starts at entry zero
    assign ram_we    = cmd.update && !same_reg;
    assign ram_waddr = open_new ? '0 : count_reg[AW-1:0];

    fdrle_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_RAW_RUN)
    ) u_raw_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pix_reg),
        .raddr (pix_idx_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next   = count_reg;
        is_same_next = is_same_reg;
        if (cmd.update)
        begin
            if (open_new)
            begin
                count_next   = LEN_W'(1);
                is_same_next = same_reg;
            end
            else if (same_reg)
            begin
                if (count_reg < MAX_FRAME_PIXELS)
                begin
                    count_next = count_reg + LEN_W'(1);
                end
            end
            else
            begin
                count_next = count_reg + LEN_W'(1);
            end
        end
        if (cmd.clear_run)
        begin
            count_next   = '0;
            is_same_next = 1'b0;
        end
    end

    // Read address runs one ahead so the pixel for the next load is ready
    always_comb
    begin
        pix_idx_next = pix_idx_reg;
        if (cmd.load_hdr)
        begin
            pix_idx_next = '0;
        end
        else if (cmd.load_pix)
        begin
            pix_idx_next = pix_idx_reg + AW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_len_next   = out_len_reg;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        if (cmd.load_hdr)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = is_same_reg ? KIND_SAME : KIND_RAW;
            out_len_next   = count_reg;
            out_pix_next   = '0;
            out_last_next  = is_same_reg && burst_end;
        end
        else if (cmd.load_pix)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_PIXEL;
            out_len_next   = '0;
            out_pix_next   = ram_rdata;
            out_last_next  = pix_final && burst_end;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            is_same_reg   <= 1'b0;
            pix_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            is_same_reg   <= is_same_next;
            pix_idx_reg   <= pix_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg  <= {cur_red, cur_green, cur_blue};
            same_reg <= ({cur_red, cur_green, cur_blue} == {ref_red, ref_green, ref_blue});
            last_reg <= frame_end;
        end
        out_kind_reg <= out_kind_next;
        out_len_reg  <= out_len_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign item_kind  = out_kind_reg;
    assign run_length = out_len_reg;
    assign out_red    = out_pix_reg[PIX_W-1 -: COLOR_W];
    assign out_green  = out_pix_reg[COLOR_W +: COLOR_W];
    assign out_blue   = out_pix_reg[COLOR_W-1:0];
    assign burst_last = out_last_reg;

    a_raw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !is_same_reg |-> (count_reg <= RAW_LIMIT))
        else $error("raw run longer than buffer");

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_FRAME_PIXELS)
        else $error("run count past frame bound");

    a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_hdr || cmd.load_pix |-> st.out_free && !(cmd.load_hdr && cmd.load_pix))
        else $error("result register loaded while busy");

endmodule

`default_nettype wire

// File: rtl/fdrle_ctrl.sv
// Controller state machine: sequences capture, run flushes and run update.
// Depends on fdrle_pkg.
`default_nettype none

module fdrle_ctrl
    import fdrle_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire ctrl_status_t st,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_HDR,
        S_PIX
    } state_t;

    state_t state_reg, state_next;
    logic   post_reg, post_next;
    logic   pre_done_reg, pre_done_next;
    logic   run_done;

    always_comb
    begin
        cmd            = '0;
        cmd.flush_post = post_reg;
        state_next     = state_reg;
        post_next      = post_reg;
        pre_done_next  = pre_done_reg;
        run_done       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture   = 1'b1;
                    pre_done_next = 1'b0;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (st.pre_flush && !pre_done_reg)
                begin
                    post_next  = 1'b0;
                    state_next = S_HDR;
                end
                else
                begin
                    cmd.update = 1'b1;
                    if (st.last)
                    begin
                        post_next  = 1'b1;
                        state_next = S_HDR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_HDR:
            begin
                if (st.out_free)
                begin
                    cmd.load_hdr = 1'b1;
                    if (st.run_same)
                    begin
                        run_done = 1'b1;
                    end
                    else
                    begin
                        state_next = S_PIX;
                    end
                end
            end
            S_PIX:
            begin
                if (st.out_free)
                begin
                    cmd.load_pix = 1'b1;
                    run_done     = st.pix_final;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Close the run: frame end clears it, a mid-frame flush resumes the update
        if (run_done)
        begin
            if (post_reg)
            begin
                cmd.clear_run = 1'b1;
                state_next    = S_IDLE;
            end
            else
            begin
                pre_done_next = 1'b1;
                state_next    = S_EVAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            post_reg     <= 1'b0;
            pre_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            post_reg     <= post_next;
            pre_done_reg <= pre_done_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_pix_raw_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIX) |-> !st.run_same)
        else $error("pixel burst on a same run");

    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_run |-> st.last && post_reg)
        else $error("run cleared outside frame end");

    a_update_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !(st.pre_flush && !pre_done_reg))
        else $error("run updated before old run flushed");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the frame delta run-length encoder.
// Depends on fdrle_pkg and frame_delta_run_length_encoder_top; a scoreboard class predicts
// every header and raw pixel item, a task drives the input handshake and a process the output one.
module testbench;
    import fdrle_pkg::*;

    localparam int RAW_RUN_MAX = MAX_RAW_RUN_DEF;
    localparam int PERIOD      = 12;

    // One predicted result item, at the widths of the output ports
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } run_item_t;

    // Run-length predictor plus the queue of items still owed by the block
    class run_scoreboard;
        bit                 open_same;
        logic [LEN_W-1:0]   open_len;
        logic [PIX_W-1:0]   raw_pixels [RAW_RUN_MAX];
        bit                 frame_open;
        run_item_t          owed_q [$];
        run_item_t          step_q [$];
        int                 errors;
        int                 pixels_noted;
        int                 frames_closed;
        int                 same_headers;
        int                 raw_headers;
        int                 raw_data;
        int                 longest_burst;
        int                 items_checked;

        function void emit(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len,
                           logic [PIX_W-1:0] px);
            run_item_t it;
            it.kind  = kind;
            it.len   = len;
            it.red   = px[23:16];
            it.green = px[15:8];
            it.blue  = px[7:0];
            it.last  = 1'b0;
            step_q.push_back(it);
        endfunction

        // Close the open run: header, then buffered pixels for a raw run
        function void close_run();
            if (open_len == 0)
                return;
            if (open_same)
            begin
                emit(KIND_SAME, open_len, '0);
                same_headers++;
            end
            else
            begin
                emit(KIND_RAW, open_len, '0);
                raw_headers++;
                for (int i = 0; i < open_len && i < RAW_RUN_MAX; i++)
                begin
                    emit(KIND_PIXEL, '0, raw_pixels[i]);
                    raw_data++;
                end
            end
            open_len = '0;
        endfunction

        function void start_run(bit same, logic [PIX_W-1:0] px);
            open_same = same;
            open_len  = LEN_W'(1);
            if (!same)
                raw_pixels[0] = px;
            frame_open = 1'b1;
        endfunction

        // Predict the items caused by one accepted pixel pair
        function void note_pixel(logic [PIX_W-1:0] cur, logic [PIX_W-1:0] prev_px, logic fe);
            bit        same;
            run_item_t tail;
            same = (cur == prev_px);
            step_q.delete();
            pixels_noted++;
            if (!frame_open || open_len == 0)
                start_run(same, cur);
            else if (same != open_same)
            begin
                close_run();
                start_run(same, cur);
            end
            else if (same)
            begin
                if (open_len < MAX_FRAME_PIXELS)
                    open_len++;
            end
            else if (open_len >= RAW_RUN_MAX)
            begin
                close_run();
                start_run(1'b0, cur);
            end
            else
            begin
                raw_pixels[open_len] = cur;
                open_len++;
            end
            if (fe)
            begin
                close_run();
                frame_open = 1'b0;
                open_same  = 1'b0;
                frames_closed++;
            end
            if (step_q.size() > 0)
            begin
                tail      = step_q[step_q.size() - 1];
                tail.last = 1'b1;
                step_q[step_q.size() - 1] = tail;
                if (step_q.size() > longest_burst)
                    longest_burst = step_q.size();
            end
            foreach (step_q[i])
                owed_q.push_back(step_q[i]);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len,
                                   logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                   logic [COLOR_W-1:0] b, logic last);
            run_item_t want;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual kind %0d len %0d",
                         $time, kind, len);
                return;
            end
            want = owed_q.pop_front();
            items_checked++;
            compare_field("item_kind", want.kind, kind);
            compare_field("run_length", want.len, len);
            compare_field("out_red", want.red, r);
            compare_field("out_green", want.green, g);
            compare_field("out_blue", want.blue, b);
            compare_field("burst_last", want.last, last);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [COLOR_W-1:0] cur_red;
    logic [COLOR_W-1:0] cur_green;
    logic [COLOR_W-1:0] cur_blue;
    logic [COLOR_W-1:0] ref_red;
    logic [COLOR_W-1:0] ref_green;
    logic [COLOR_W-1:0] ref_blue;
    logic               frame_end;
    logic               out_valid;
    logic               out_stall;
    logic [KIND_W-1:0]  item_kind;
    logic [LEN_W-1:0]   run_length;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               burst_last;

    run_scoreboard board;
    bit            idle_on;

    frame_delta_run_length_encoder_top #(
        .MAX_RAW_RUN (RAW_RUN_MAX)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cur_red    (cur_red),
        .cur_green  (cur_green),
        .cur_blue   (cur_blue),
        .ref_red    (ref_red),
        .ref_green  (ref_green),
        .ref_blue   (ref_blue),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .item_kind  (item_kind),
        .run_length (run_length),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .burst_last (burst_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(PERIOD / 2) clk = ~clk;

    // Gap before an item: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Random pixel, with the all-zero and all-one extremes now and then
    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return PIX_W'($urandom() & 32'h00FF_FFFF);
    endfunction

    // Reference that differs from cur: often in a single bit, else anywhere
    function automatic logic [PIX_W-1:0] differ_from(logic [PIX_W-1:0] cur);
        logic [PIX_W-1:0] mask;
        if ($urandom_range(0, 1) == 0)
            mask = 24'd1 << $urandom_range(0, PIX_W - 1);
        else
            mask = PIX_W'($urandom_range(1, 24'hFF_FFFF));
        return cur ^ mask;
    endfunction

    // Present one pixel pair at the falling edge and hold it until accepted.
    // Entered and left just after a falling edge.
    task automatic send_pixel(logic [PIX_W-1:0] cur, logic [PIX_W-1:0] prev_px, logic fe);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        cur_red   <= cur[23:16];
        cur_green <= cur[15:8];
        cur_blue  <= cur[7:0];
        ref_red   <= prev_px[23:16];
        ref_green <= prev_px[15:8];
        ref_blue  <= prev_px[7:0];
        frame_end <= fe;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        board.note_pixel(cur, prev_px, fe);
        @(negedge clk);
    endtask

    // Send a run of one kind with random content; optionally end the frame on its last pixel
    task automatic send_run(bit same, int len, bit close_frame);
        logic [PIX_W-1:0] cur;
        for (int i = 0; i < len; i++)
        begin
            cur = pick_pixel();
            send_pixel(cur, same ? cur : differ_from(cur), close_frame && (i == len - 1));
        end
    endtask

    // Run length: mostly short, some around the raw run limit, a few around two full runs
    function automatic int pick_run_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 4);
        else if (r < 80)
            return $urandom_range(5, 12);
        else if (r < 93)
            return $urandom_range(RAW_RUN_MAX - 1, RAW_RUN_MAX + 2);
        else
            return $urandom_range(2 * RAW_RUN_MAX - 2, 2 * RAW_RUN_MAX + 2);
    endfunction

    // Receiver: stall in stretches of random length; free stretches, short stalls, rare long ones
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            int r;
            r = $urandom_range(0, 99);
            @(negedge clk);
            if (r < 40)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
            else if (r < 92)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check every accepted result item against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(item_kind, run_length, out_red, out_green, out_blue, burst_last);
    end

    // Stimulus: directed corner pixels, then random frames built from runs
    initial
    begin
        int target;
        board     = new();
        idle_on   = 1'b1;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cur_red   = '0;
        cur_green = '0;
        cur_blue  = '0;
        ref_red   = '0;
        ref_green = '0;
        ref_blue  = '0;
        frame_end = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-pixel frames at the extremes, same and raw
        send_pixel(24'h000000, 24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 24'h000000, 1'b1);
        send_pixel(24'h000000, 24'hFFFFFF, 1'b1);
        send_pixel(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        // Same run, then a raw run whose pixels differ in one channel each
        send_pixel(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 24'h000000, 1'b0);
        send_pixel(24'hFF0000, 24'hFE0000, 1'b0);
        send_pixel(24'h00FF00, 24'h00FE00, 1'b0);
        send_pixel(24'h0000FF, 24'h0000FE, 1'b0);
        // Back to same, closed by the end of the frame
        send_pixel(24'h808080, 24'h808080, 1'b0);
        send_pixel(24'h7F7F7F, 24'h7F7F7F, 1'b1);
        // Kind change on the last pixel: two runs flushed by one item
        send_pixel(24'h010203, 24'h010203, 1'b0);
        send_pixel(24'hAAAAAA, 24'h555555, 1'b1);
        send_pixel(24'h55AA55, 24'hAA55AA, 1'b0);
        send_pixel(24'h123456, 24'h123456, 1'b1);
        // Raw run opened mid-frame and flushed by the frame end on a raw pixel
        send_pixel(24'h00FFFF, 24'h00FFFE, 1'b0);
        send_pixel(24'hFFFF00, 24'h7FFF00, 1'b1);

        // Full raw run broken by one more raw pixel at the frame end: the longest burst
        target = 210;
        send_run(1'b0, RAW_RUN_MAX + 1, 1'b1);

        while (board.pixels_noted < target)
        begin
            int runs;
            bit kind;
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: unrelated pixel pairs, random frame ends
                repeat ($urandom_range(1, 6))
                    send_pixel(pick_pixel(), pick_pixel(), $urandom_range(0, 3) == 0);
            end
            else
            begin
                runs = $urandom_range(1, 5);
                kind = 1'($urandom_range(0, 1));
                for (int k = 0; k < runs && board.pixels_noted < target; k++)
                begin
                    send_run(kind, pick_run_len(),
                             (k == runs - 1) && ($urandom_range(0, 99) < 85));
                    // Mostly alternate kinds; sometimes repeat one to merge runs
                    if ($urandom_range(0, 4) != 0)
                        kind = !kind;
                end
            end
        end
        in_valid <= 1'b0;
        idle_on  = 1'b1;

        // Drain: wait for every owed item, then idle on to catch strays
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d pixels in %0d closed frames; checked %0d result items.",
                 board.pixels_noted, board.frames_closed, board.items_checked);
        $display("Runs: %0d same headers, %0d raw headers, %0d raw pixels, longest burst %0d.",
                 board.same_headers, board.raw_headers, board.raw_data, board.longest_burst);
        if (board.errors == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #40000000;
        $display("Timeout at %0t with %0d items still owed", $time, board.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/fdrle_pkg.sv
rtl/fdrle_ram.sv
rtl/fdrle_datapath.sv
rtl/fdrle_ctrl.sv
rtl/frame_delta_run_length_encoder_top.sv
tb/testbench.sv
